// File: rtl/core/iprc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iprc_pkg
// Shared types, state codes and register map of the IR passage relay
// controller.
// ----------------------------------------------------------------------------
package iprc_pkg;

	localparam int CFG_IDX_W = 4;

	localparam logic [CFG_IDX_W-1:0] REG_SINGLE_TIMEOUT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_DUAL_TIMEOUT   = CFG_IDX_W'(1);

	localparam logic [31:0] SINGLE_TIMEOUT_RST = 32'd1000;
	localparam logic [31:0] DUAL_TIMEOUT_RST   = 32'd1000;

	localparam logic [2:0] ST_IDLE         = 3'd0;
	localparam logic [2:0] ST_A_FIRED      = 3'd1;
	localparam logic [2:0] ST_B_FIRED      = 3'd2;
	localparam logic [2:0] ST_WAIT_A_CLEAR = 3'd3;
	localparam logic [2:0] ST_WAIT_B_CLEAR = 3'd4;

	typedef struct packed {
		logic        first_lit_read_a;
		logic        dark_read_a;
		logic        second_lit_read_a;
		logic        first_lit_read_b;
		logic        dark_read_b;
		logic        second_lit_read_b;
		logic        strap_a;
		logic        strap_b;
		logic [31:0] now_ms;
	} req_t;

	typedef struct packed {
		logic       relay_on;
		logic [2:0] fsm_state;
	} rsp_t;

	typedef struct packed {
		logic [31:0] single_timeout;
		logic [31:0] dual_timeout;
	} cfg_t;

	typedef struct packed {
		logic       relay;
		logic [2:0] state;
	} status_t;

	// low, high, low across LED on / off / on
	function automatic logic fired(input logic lit1, input logic dark, input logic lit2);
		return !lit1 && dark && !lit2;
	endfunction

	function automatic logic single_mode(input req_t r);
		return r.strap_a ^ r.strap_b;
	endfunction

endpackage

// File: rtl/core/ir_passage_relay_controller_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_passage_relay_controller_core
// IR passage relay controller: one polling pass per request, relay level and
// direction state returned per pass.
//
//   channel  signals                                 direction
//   req      req_valid, req_ready, req_data          in
//   rsp      rsp_valid, rsp_ready, rsp_data          out
//   cfg      cfg_valid, cfg_ready, cfg_index/_data   in
//
// One request per cycle while rsp is not stalled; a request goes from the input
// register to the result register, with the state update between them.
// Reset clears state, relay and both valid flags; timeouts reset to 1000 ms.
// A stalled result holds the request register; ready ripples back from rsp.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
module ir_passage_relay_controller_core
	import iprc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  req_t                 req_data,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output rsp_t                 rsp_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);

	logic    req_valid_s1;
	req_t    req_s1;
	logic    rsp_valid_s2;
	rsp_t    rsp_data_s2;
	logic    adv;
	cfg_t    cfg;
	status_t cur;
	status_t nxt;

	assign adv       = req_valid_s1 && (!rsp_valid_s2 || rsp_ready);
	assign req_ready = !req_valid_s1 || adv;

	iprc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	iprc_tracker u_tracker (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.req    (req_s1),
		.cfg    (cfg),
		.cur    (cur),
		.nxt    (nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (req_ready) begin
			req_valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			req_s1 <= req_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_s2 <= 1'b0;
		end else if (!rsp_valid_s2 || rsp_ready) begin
			rsp_valid_s2 <= req_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_data_s2.relay_on  <= nxt.relay;
			rsp_data_s2.fsm_state <= nxt.state;
		end
	end

	assign rsp_valid = rsp_valid_s2;
	assign rsp_data  = rsp_data_s2;

	a_state_tracks_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> (cur.state == rsp_data_s2.fsm_state && cur.relay == rsp_data_s2.relay_on))
		else $error("tracker state differs from last result");

	a_single_trigger_relay: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && single_mode(req_s1)
			&& (fired(req_s1.first_lit_read_a, req_s1.dark_read_a, req_s1.second_lit_read_a)
			|| fired(req_s1.first_lit_read_b, req_s1.dark_read_b, req_s1.second_lit_read_b)))
		|=> rsp_data_s2.relay_on)
		else $error("trigger in one-sensor mode left relay off");

	a_dual_pass_through: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && !single_mode(req_s1) && cur.state == ST_A_FIRED
			&& fired(req_s1.first_lit_read_b, req_s1.dark_read_b, req_s1.second_lit_read_b))
		|=> (rsp_data_s2.fsm_state == ST_WAIT_B_CLEAR && !rsp_data_s2.relay_on))
		else $error("A then B pass did not release relay");

	a_state_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_data.fsm_state <= ST_WAIT_B_CLEAR))
		else $error("result carries undefined direction state");

endmodule

// File: rtl/core/iprc_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iprc_cfg_regs
// Timeout registers, written through the configuration channel.
// ----------------------------------------------------------------------------
module iprc_cfg_regs
	import iprc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	output cfg_t                 cfg
);

	logic [31:0] single_timeout_q;
	logic [31:0] dual_timeout_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			single_timeout_q <= SINGLE_TIMEOUT_RST;
			dual_timeout_q   <= DUAL_TIMEOUT_RST;
		end else if (cfg_valid) begin
			if (cfg_index == REG_SINGLE_TIMEOUT) begin
				single_timeout_q <= cfg_data;
			end
			if (cfg_index == REG_DUAL_TIMEOUT) begin
				dual_timeout_q <= cfg_data;
			end
		end
	end

	assign cfg.single_timeout = single_timeout_q;
	assign cfg.dual_timeout   = dual_timeout_q;

endmodule

// File: rtl/core/iprc_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iprc_tracker
// Relay level, direction machine and trigger timestamp; one pass per enable.
// ----------------------------------------------------------------------------
module iprc_tracker
	import iprc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  req_t    req,
	input  cfg_t    cfg,
	output status_t cur,
	output status_t nxt
);

	logic [2:0]  state_q;
	logic [31:0] last_time_q;
	logic        relay_q;

	logic [2:0]  state_d;
	logic [31:0] last_time_d;
	logic        relay_d;

	logic        sa;
	logic        sb;
	logic        single;
	logic [31:0] limit;
	logic [31:0] elapsed;
	logic        expired;

	assign sa      = fired(req.first_lit_read_a, req.dark_read_a, req.second_lit_read_a);
	assign sb      = fired(req.first_lit_read_b, req.dark_read_b, req.second_lit_read_b);
	assign single  = single_mode(req);
	assign limit   = single ? cfg.single_timeout : cfg.dual_timeout;
	assign elapsed = req.now_ms - last_time_q;
	assign expired = elapsed > limit;

	always_comb begin
		state_d     = state_q;
		last_time_d = last_time_q;
		relay_d     = relay_q;
		if (single) begin
			priority if (sa || sb) begin
				relay_d     = 1'b1;
				last_time_d = req.now_ms;
			end else if (expired) begin
				relay_d = 1'b0;
			end else begin
				relay_d = relay_q;
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					priority if (sb) begin
						state_d = ST_B_FIRED;
					end else if (sa) begin
						state_d = ST_A_FIRED;
					end else begin
						state_d = state_q;
					end
				end
				ST_A_FIRED: begin
					relay_d = 1'b1;
					if (sb) begin
						relay_d     = 1'b0;
						last_time_d = req.now_ms;
						state_d     = ST_WAIT_B_CLEAR;
					end
				end
				ST_B_FIRED: begin
					relay_d = 1'b1;
					if (sa) begin
						relay_d     = 1'b0;
						last_time_d = req.now_ms;
						state_d     = ST_WAIT_A_CLEAR;
					end
				end
				ST_WAIT_A_CLEAR: begin
					priority if (sa) begin
						last_time_d = req.now_ms;
					end else if (expired) begin
						state_d = ST_IDLE;
					end else begin
						state_d = state_q;
					end
				end
				ST_WAIT_B_CLEAR: begin
					priority if (sb) begin
						last_time_d = req.now_ms;
					end else if (expired) begin
						state_d = ST_IDLE;
					end else begin
						state_d = state_q;
					end
				end
				default: begin
					state_d = ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			last_time_q <= 32'd0;
			relay_q     <= 1'b0;
		end else if (en) begin
			state_q     <= state_d;
			last_time_q <= last_time_d;
			relay_q     <= relay_d;
		end
	end

	assign cur.relay = relay_q;
	assign cur.state = state_q;
	assign nxt.relay = relay_d;
	assign nxt.state = state_d;

endmodule

// File: tb/tb_ir_passage_relay_controller_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ir_passage_relay_controller_core
// Self-checking bench for the IR passage relay controller. Polling passes go
// in through the request channel and each result is checked against a local
// model of the relay, the direction machine and both timeouts. A short
// directed run covers triggers, both modes, mode changes and time wrap. Then
// random passes run under several timeout settings, including 0 and all ones,
// with random idles and stalls on both sides, a long result back-pressure
// and a sender pause until all results are back.
// ----------------------------------------------------------------------------
module tb_ir_passage_relay_controller_core;
	import iprc_pkg::*;

	localparam logic [2:0] FIRE_PATTERN = 3'b010;
	localparam logic [2:0] QUIET        = 3'b000;
	localparam logic [1:0] DUAL_LOW     = 2'b00;
	localparam logic [1:0] DUAL_HIGH    = 2'b11;
	localparam logic [1:0] ONE_A        = 2'b01;
	localparam logic [1:0] ONE_B        = 2'b10;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES  = 150;

	typedef enum int {MIX_MODES, DUAL_HEAVY, SINGLE_HEAVY} mode_mix_e;

	class relay_predictor;
		rsp_t        expected_q[$];
		logic [31:0] single_timeout;
		logic [31:0] dual_timeout;
		logic [31:0] stamp_ms;
		logic [2:0]  dir_state;
		logic        relay;
		int          errors;
		int          checked;
		int          single_passes;
		int          state_hits[5];

		function new();
			single_timeout = SINGLE_TIMEOUT_RST;
			dual_timeout = DUAL_TIMEOUT_RST;
			stamp_ms = '0;
			dir_state = ST_IDLE;
			relay = 1'b0;
			errors = 0;
			checked = 0;
			single_passes = 0;
			foreach (state_hits[i]) state_hits[i] = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
			case (idx)
				REG_SINGLE_TIMEOUT: single_timeout = val;
				REG_DUAL_TIMEOUT: dual_timeout = val;
				default: ;
			endcase
		endfunction

		function void note_pass(req_t r);
			logic        hit_a;
			logic        hit_b;
			logic [31:0] since;
			rsp_t        want;
			hit_a = {r.first_lit_read_a, r.dark_read_a, r.second_lit_read_a} == FIRE_PATTERN;
			hit_b = {r.first_lit_read_b, r.dark_read_b, r.second_lit_read_b} == FIRE_PATTERN;
			since = r.now_ms - stamp_ms;
			if (r.strap_a ^ r.strap_b) begin
				single_passes++;
				if (hit_a || hit_b) begin
					relay = 1'b1;
					stamp_ms = r.now_ms;
				end else if (since > single_timeout) begin
					relay = 1'b0;
				end
			end else begin
				case (dir_state)
					ST_IDLE: begin
						if (hit_a) dir_state = ST_A_FIRED;
						if (hit_b) dir_state = ST_B_FIRED;
					end
					ST_A_FIRED: begin
						relay = 1'b1;
						if (hit_b) begin
							relay = 1'b0;
							stamp_ms = r.now_ms;
							dir_state = ST_WAIT_B_CLEAR;
						end
					end
					ST_B_FIRED: begin
						relay = 1'b1;
						if (hit_a) begin
							relay = 1'b0;
							stamp_ms = r.now_ms;
							dir_state = ST_WAIT_A_CLEAR;
						end
					end
					ST_WAIT_A_CLEAR: begin
						if (hit_a) stamp_ms = r.now_ms;
						else if (since > dual_timeout) dir_state = ST_IDLE;
					end
					ST_WAIT_B_CLEAR: begin
						if (hit_b) stamp_ms = r.now_ms;
						else if (since > dual_timeout) dir_state = ST_IDLE;
					end
					default: dir_state = ST_IDLE;
				endcase
			end
			state_hits[dir_state]++;
			want.relay_on = relay;
			want.fsm_state = dir_state;
			expected_q.push_back(want);
		endfunction

		function void check_result(rsp_t got);
			rsp_t want;
			if (expected_q.size() == 0) begin
				$display("%0t unexpected result: expected none, got relay_on %0b fsm_state %0d",
					$time, got.relay_on, got.fsm_state);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			checked++;
			if (got.relay_on !== want.relay_on) begin
				$display("%0t relay_on mismatch: expected %0b, got %0b",
					$time, want.relay_on, got.relay_on);
				errors++;
			end
			if (got.fsm_state !== want.fsm_state) begin
				$display("%0t fsm_state mismatch: expected %0d, got %0d",
					$time, want.fsm_state, got.fsm_state);
				errors++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 req_valid;
	logic                 req_ready;
	req_t                 req_data;
	logic                 rsp_valid;
	logic                 rsp_ready;
	rsp_t                 rsp_data;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0]          cfg_data;

	relay_predictor predictor;
	logic [31:0]    clock_ms;
	bit             tx_idle;
	bit             rx_idle;
	int             rx_hold;
	int             settings;
	int             cycles;

	ir_passage_relay_controller_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_data(req_data),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp_data(rsp_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	function automatic req_t make_pass(logic [2:0] a, logic [2:0] b, logic [1:0] straps,
			logic [31:0] now);
		req_t r;
		{r.first_lit_read_a, r.dark_read_a, r.second_lit_read_a} = a;
		{r.first_lit_read_b, r.dark_read_b, r.second_lit_read_b} = b;
		{r.strap_a, r.strap_b} = straps;
		r.now_ms = now;
		return r;
	endfunction

	function automatic req_t random_pass(mode_mix_e mix, logic [31:0] step);
		logic [2:0] a;
		logic [2:0] b;
		logic [1:0] straps;
		bit         one_sensor;
		int         roll;
		a = ($urandom_range(0, 3) == 0) ? FIRE_PATTERN : 3'($urandom);
		b = ($urandom_range(0, 3) == 0) ? FIRE_PATTERN : 3'($urandom);
		roll = $urandom_range(0, 9);
		case (mix)
			DUAL_HEAVY: one_sensor = (roll == 0);
			SINGLE_HEAVY: one_sensor = (roll != 0);
			default: one_sensor = (roll < 5);
		endcase
		if (one_sensor) straps = $urandom_range(0, 1) ? ONE_A : ONE_B;
		else straps = $urandom_range(0, 1) ? DUAL_LOW : DUAL_HIGH;
		if ($urandom_range(0, 32) == 0) clock_ms = $urandom;
		else clock_ms = clock_ms + $urandom_range(0, step);
		return make_pass(a, b, straps, clock_ms);
	endfunction

	task automatic send_pass(input req_t r);
		int gap;
		gap = tx_idle ? $urandom_range(0, 13) : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_data <= r;
		do @(posedge clk); while (!req_ready);
		predictor.note_pass(r);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		predictor.write_reg(idx, val);
	endtask

	task automatic wait_for_results();
		while (predictor.pending() != 0) @(posedge clk);
	endtask

	// unmapped index in between; the block must ignore it
	task automatic configure(input logic [31:0] single_to, input logic [31:0] dual_to);
		logic [CFG_IDX_W-1:0] junk;
		junk = CFG_IDX_W'($urandom_range(REG_DUAL_TIMEOUT + 1, 2 ** CFG_IDX_W - 1));
		if ($urandom_range(0, 1)) begin
			write_reg(REG_SINGLE_TIMEOUT, single_to);
			write_reg(junk, $urandom);
			write_reg(REG_DUAL_TIMEOUT, dual_to);
		end else begin
			write_reg(REG_DUAL_TIMEOUT, dual_to);
			write_reg(junk, $urandom);
			write_reg(REG_SINGLE_TIMEOUT, single_to);
		end
		cfg_valid <= 1'b0;
		settings++;
	endtask

	task automatic run_phase(input logic [31:0] single_to, input logic [31:0] dual_to,
			input int n, input mode_mix_e mix, input logic [31:0] step,
			input bit squeeze, input bit pause);
		wait_for_results();
		configure(single_to, dual_to);
		for (int i = 0; i < n; i++) begin
			if (i % 40 == 0) begin
				tx_idle = $urandom_range(0, 2) != 0;
				rx_idle = $urandom_range(0, 2) != 0;
			end
			if (squeeze && i == n / 4) begin
				tx_idle = 1'b0;
				rx_hold = HOLD_CYCLES;
			end
			if (pause && i == n / 2) begin
				req_valid <= 1'b0;
				wait_for_results();
			end
			send_pass(random_pass(mix, step));
		end
		req_valid <= 1'b0;
	endtask

	task automatic directed_passes();
		send_pass(make_pass(QUIET, QUIET, DUAL_LOW, 32'd0));
		send_pass(make_pass(3'b111, 3'b111, DUAL_HIGH, 32'hFFFF_FFFF));
		send_pass(make_pass(FIRE_PATTERN, QUIET, DUAL_HIGH, 32'd10));
		send_pass(make_pass(3'b011, 3'b110, DUAL_HIGH, 32'd20));
		send_pass(make_pass(QUIET, FIRE_PATTERN, DUAL_HIGH, 32'd30));
		send_pass(make_pass(QUIET, FIRE_PATTERN, DUAL_LOW, 32'd500));
		send_pass(make_pass(QUIET, QUIET, DUAL_HIGH, 32'd1500));
		send_pass(make_pass(QUIET, QUIET, DUAL_HIGH, 32'd1501));
		// both fire from idle: B wins
		send_pass(make_pass(FIRE_PATTERN, FIRE_PATTERN, DUAL_HIGH, 32'd1600));
		send_pass(make_pass(QUIET, QUIET, DUAL_HIGH, 32'd1700));
		send_pass(make_pass(FIRE_PATTERN, QUIET, DUAL_HIGH, 32'd1800));
		send_pass(make_pass(FIRE_PATTERN, QUIET, DUAL_HIGH, 32'd2000));
		send_pass(make_pass(3'b101, 3'b101, DUAL_HIGH, 32'd3001));
		send_pass(make_pass(FIRE_PATTERN, QUIET, DUAL_HIGH, 32'd3100));
		// mode change: one-sensor passes leave the direction state alone
		send_pass(make_pass(QUIET, FIRE_PATTERN, ONE_A, 32'd3200));
		send_pass(make_pass(QUIET, QUIET, ONE_A, 32'd4200));
		send_pass(make_pass(QUIET, QUIET, ONE_B, 32'd4201));
		send_pass(make_pass(QUIET, QUIET, DUAL_HIGH, 32'd4300));
		send_pass(make_pass(QUIET, FIRE_PATTERN, DUAL_HIGH, 32'd4400));
		// elapsed time across the 32-bit wrap
		send_pass(make_pass(FIRE_PATTERN, QUIET, ONE_B, 32'hFFFF_FF00));
		send_pass(make_pass(QUIET, QUIET, ONE_A, 32'h0000_02E7));
		send_pass(make_pass(QUIET, QUIET, ONE_A, 32'h0000_02E9));
		send_pass(make_pass(QUIET, QUIET, DUAL_HIGH, 32'h0000_02E9));
		send_pass(make_pass(FIRE_PATTERN, FIRE_PATTERN, ONE_A, 32'h7FFF_FFFF));
		send_pass(make_pass(QUIET, QUIET, DUAL_LOW, 32'd0));
		req_valid <= 1'b0;
	endtask

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("status: fail");
		$finish;
	end

	initial begin
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			if (rx_hold > 0) begin
				stall = rx_hold;
				rx_hold = 0;
			end else begin
				stall = rx_idle ? $urandom_range(0, 13) : 0;
			end
			if (stall > 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
			predictor.check_result(rsp_data);
		end
	end

	initial begin
		logic [31:0] single_pick;
		logic [31:0] dual_pick;
		clk = 1'b0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_data = '0;
		rsp_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		rx_hold = 0;
		settings = 1;
		cycles = 0;
		clock_ms = '0;
		predictor = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_passes();

		run_phase(32'd0, 32'd0, 120, MIX_MODES, 32'd3, 1'b0, 1'b0);
		clock_ms = 32'hFFFF_FF00;
		run_phase(32'd7, 32'd25, 200, DUAL_HEAVY, 32'd8, 1'b1, 1'b0);
		run_phase('1, '1, 80, MIX_MODES, '1, 1'b0, 1'b0);
		run_phase(32'd15, 32'd3, 200, SINGLE_HEAVY, 32'd6, 1'b0, 1'b1);
		clock_ms = 32'hFFFF_FFC0;
		single_pick = $urandom_range(0, 60);
		dual_pick = $urandom_range(0, 60);
		run_phase(single_pick, dual_pick, 200, MIX_MODES, 32'd20, 1'b1, 1'b1);
		run_phase(32'h8000_0000, 32'd1, 100, MIX_MODES, '1, 1'b0, 1'b0);
		run_phase(SINGLE_TIMEOUT_RST, DUAL_TIMEOUT_RST, 100, DUAL_HEAVY, 32'd300, 1'b0, 1'b0);

		wait_for_results();
		rx_idle = 1'b0;
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("checked %0d relay results over %0d timeout settings, %0d one-sensor passes",
			predictor.checked, settings, predictor.single_passes);
		$display("direction states seen: idle %0d, A %0d, B %0d, wait A %0d, wait B %0d",
			predictor.state_hits[0], predictor.state_hits[1], predictor.state_hits[2],
			predictor.state_hits[3], predictor.state_hits[4]);
		if (predictor.errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
